@@ rtl/kwm_pkg.sv @@
package kwm_pkg;

  localparam int LISTS    = 8;
  localparam int CAPACITY = 64;

  localparam int IN_LIST_W = 3;
  localparam int VAL_W     = 32;
  localparam int LIDX_W    = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int LVLS      = LIDX_W;
  localparam int LP        = 1 << LVLS;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                     store;
    logic                     last;
    logic                     ovf;
    logic [LIDX_W-1:0]        lidx;
    logic signed [VAL_W-1:0]  val;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  merged_value;
    logic [IN_LIST_W-1:0]     source_list;
    logic                     final_res;
    logic                     empty_res;
    logic                     overflow;
  } res_t;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_PICK  = 4'b0010,
    ST_ADV   = 4'b0100,
    ST_EMPTY = 4'b1000
  } state_e;

endpackage

@@ rtl/kwm_front.sv @@
module kwm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [kwm_pkg::IN_LIST_W-1:0] list_index_i,
  input  logic signed [kwm_pkg::VAL_W-1:0] value_i,
  input  logic                          has_value_i,
  input  logic                          last_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output kwm_pkg::cmd_t                 q_data_o
);
  import kwm_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             accept, in_range, room, store, drop;

  assign full_o   = q_full_i;
  assign accept   = push_i && !q_full_i;
  assign in_range = int'(list_index_i) < LISTS;
  assign room     = cnt_q < CNT_W'(CAPACITY);
  assign store    = accept && has_value_i && in_range && room;
  assign drop     = accept && has_value_i && in_range && !room;

  // forward only items that change something
  assign q_push_o       = store || (accept && last_i);
  assign q_data_o.store = store;
  assign q_data_o.last  = last_i;
  assign q_data_o.ovf   = ovf_q | drop;
  assign q_data_o.lidx  = LIDX_W'(list_index_i);
  assign q_data_o.val   = value_i;

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept && last_i) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end else begin
      if (store) cnt_d = cnt_q + CNT_W'(1);
      if (drop) ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

@@ rtl/kwm_cmd_queue.sv @@
module kwm_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kwm_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output kwm_pkg::cmd_t rdata_o
);
  import kwm_pkg::*;

  cmd_t             mem_q [QDEPTH];
  logic [QAW-1:0]   wr_q, rd_q;
  logic [QCW-1:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == QCW'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QAW'(1);
      if (do_pop) rd_q <= rd_q + QAW'(1);
      cnt_q <= cnt_q + QCW'(do_push) - QCW'(do_pop);
    end
  end

endmodule

@@ rtl/kwm_back.sv @@
module kwm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  kwm_pkg::cmd_t         cmd_i,
  output logic                  cmd_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output kwm_pkg::res_t         res_o
);
  import kwm_pkg::*;

  typedef struct packed {
    logic                    valid;
    logic                    more;
    logic signed [VAL_W-1:0] val;
    logic [LIDX_W-1:0]       idx;
  } node_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       ptr;
    logic signed [VAL_W-1:0] val;
  } link_t;

  // per list: element count, current head value and address, tail address
  logic [CNT_W-1:0]        lcnt_q   [LISTS];
  logic signed [VAL_W-1:0] hval_q   [LISTS];
  logic [ADDR_W-1:0]       hptr_q   [LISTS];
  logic [ADDR_W-1:0]       tail_q   [LISTS];

  // entry a holds address and value of the element after a in its list
  link_t                   link_mem [CAPACITY];
  link_t                   rd_q;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        total_q, total_d;
  logic                    ovf_q, ovf_d;
  logic [LIDX_W-1:0]       win_q;

  node_t                   tree [1:2*LP-1];
  node_t                   best;

  res_t                    ob_q [2];
  logic                    ob_wr_q, ob_rd_q;
  logic [1:0]              ob_cnt_q;
  logic                    room, emit, ob_pop;
  res_t                    emit_res;

  logic                    do_store, go_merge, pick_fire, issue_rd;

  // min tree over the list heads; the higher list wins a tie
  always_comb begin
    for (int i = 0; i < LP; i++) begin
      if (i < LISTS) begin
        tree[LP+i].valid = lcnt_q[i] != '0;
        tree[LP+i].more  = lcnt_q[i] > CNT_W'(1);
        tree[LP+i].val   = hval_q[i];
      end else begin
        tree[LP+i].valid = 1'b0;
        tree[LP+i].more  = 1'b0;
        tree[LP+i].val   = '0;
      end
      tree[LP+i].idx = LIDX_W'(i);
    end
    for (int n = LP - 1; n >= 1; n--) begin
      if (tree[2*n+1].valid &&
          (!tree[2*n].valid || tree[2*n+1].val <= tree[2*n].val)) begin
        tree[n] = tree[2*n+1];
      end else begin
        tree[n] = tree[2*n];
      end
    end
    best = tree[1];
  end

  assign room     = ob_cnt_q != 2'd2;
  assign ob_pop   = pop_i && (ob_cnt_q != 2'd0);
  assign empty_o  = ob_cnt_q == 2'd0;
  assign res_o    = ob_q[ob_rd_q];

  assign cmd_pop_o = (state_q == ST_LOAD) && cmd_valid_i;
  assign do_store  = cmd_pop_o && cmd_i.store;
  assign go_merge  = cmd_pop_o && cmd_i.last;
  assign pick_fire = (state_q == ST_PICK) && room;
  assign issue_rd  = pick_fire && best.more;

  always_comb begin
    emit                  = 1'b0;
    emit_res.merged_value = best.val;
    emit_res.source_list  = IN_LIST_W'(best.idx);
    emit_res.final_res    = total_q == CNT_W'(1);
    emit_res.empty_res    = 1'b0;
    emit_res.overflow     = ovf_q;
    state_d               = state_q;
    total_d               = total_q;
    ovf_d                 = ovf_q;
    case (state_q)
      ST_LOAD: begin
        if (do_store) total_d = total_q + CNT_W'(1);
        if (go_merge) begin
          ovf_d   = cmd_i.ovf;
          state_d = (total_d == '0) ? ST_EMPTY : ST_PICK;
        end
      end
      ST_PICK: begin
        if (pick_fire) begin
          emit    = 1'b1;
          total_d = total_q - CNT_W'(1);
          if (best.more) begin
            state_d = ST_ADV;
          end else if (total_q == CNT_W'(1)) begin
            state_d = ST_LOAD;
            ovf_d   = 1'b0;
          end
        end
      end
      ST_ADV: begin
        state_d = ST_PICK;
      end
      ST_EMPTY: begin
        emit_res.merged_value = '0;
        emit_res.source_list  = '0;
        emit_res.final_res    = 1'b1;
        emit_res.empty_res    = 1'b1;
        if (room) begin
          emit    = 1'b1;
          state_d = ST_LOAD;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      total_q  <= '0;
      ovf_q    <= 1'b0;
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
      for (int i = 0; i < LISTS; i++) lcnt_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      ovf_q    <= ovf_d;
      if (emit) ob_wr_q <= ~ob_wr_q;
      if (ob_pop) ob_rd_q <= ~ob_rd_q;
      ob_cnt_q <= ob_cnt_q + 2'(emit) - 2'(ob_pop);
      if (do_store) lcnt_q[cmd_i.lidx] <= lcnt_q[cmd_i.lidx] + CNT_W'(1);
      if (pick_fire) lcnt_q[best.idx] <= lcnt_q[best.idx] - CNT_W'(1);
    end
  end

  // heads, tails and result words
  always_ff @(posedge clk_i) begin
    if (emit) ob_q[ob_wr_q] <= emit_res;
    if (do_store) begin
      tail_q[cmd_i.lidx] <= total_q[ADDR_W-1:0];
      if (lcnt_q[cmd_i.lidx] == '0) begin
        hval_q[cmd_i.lidx] <= cmd_i.val;
        hptr_q[cmd_i.lidx] <= total_q[ADDR_W-1:0];
      end
    end
    if (issue_rd) win_q <= best.idx;
    if (state_q == ST_ADV) begin
      hval_q[win_q] <= rd_q.val;
      hptr_q[win_q] <= rd_q.ptr;
    end
  end

  // link memory: append at the list's tail, follow from its head
  always_ff @(posedge clk_i) begin
    if (do_store && (lcnt_q[cmd_i.lidx] != '0)) begin
      link_mem[tail_q[cmd_i.lidx]] <= '{ptr: total_q[ADDR_W-1:0], val: cmd_i.val};
    end
    if (issue_rd) rd_q <= link_mem[hptr_q[best.idx]];
  end

endmodule

@@ rtl/k_way_sorted_merge_unit.sv @@
// Loading: one word per cycle while full is low; the command queue is four deep.
// Merge starts once the last word has left the command queue: one result per
// cycle while the output buffer has room and the winner's list runs dry, an
// advance state in between when its next element comes from the link memory.
// An empty data set gives its single result once the output buffer has room.
// Reset clears all control state; stored elements need no clearing.
module k_way_sorted_merge_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [kwm_pkg::IN_LIST_W-1:0]       list_index_i,
  input  logic signed [kwm_pkg::VAL_W-1:0]    value_i,
  input  logic                                has_value_i,
  input  logic                                last_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [kwm_pkg::VAL_W-1:0]    merged_value_o,
  output logic [kwm_pkg::IN_LIST_W-1:0]       source_list_o,
  output logic                                final_res_o,
  output logic                                empty_res_o,
  output logic                                overflow_o
);
  import kwm_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_wdata, q_rdata;
  res_t res;

  kwm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .list_index_i (list_index_i),
    .value_i      (value_i),
    .has_value_i  (has_value_i),
    .last_i       (last_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  kwm_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  kwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_rdata),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign merged_value_o = res.merged_value;
  assign source_list_o  = res.source_list;
  assign final_res_o    = res.final_res;
  assign empty_res_o    = res.empty_res;
  assign overflow_o     = res.overflow;

endmodule
